// ===== sv/ecdt_pkg.sv =====
// Shared constants, types and small tables for the epoch-to-civil-datetime unit.
// Holds the reciprocal constants used for the divisions by constants.
// No dependencies.
package ecdt_pkg;

  localparam int unsigned STAGES = 7;

  // field widths
  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DOM_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  // internal widths
  localparam int unsigned DAYS_W = 16;  // days since epoch, up to 49710
  localparam int unsigned SOD_W  = 17;  // second of day
  localparam int unsigned Z_W    = 20;  // days since 0000-03-01
  localparam int unsigned ERA_W  = 3;
  localparam int unsigned DOE_W  = 18;  // day of era
  localparam int unsigned YOE_W  = 9;   // year of era
  localparam int unsigned DOY_W  = 9;   // day of March-based year
  localparam int unsigned REM_W  = 12;  // second of hour
  localparam int unsigned Q36_W  = 3;
  localparam int unsigned Q100_W = 2;
  localparam int unsigned MP_W   = 4;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned SECS_PER_HR  = 3600;
  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned DAY_SHIFT    = 719468;
  localparam int unsigned DAYS_PER_ERA = 146097;
  localparam int unsigned DAYS_PER_CEN = 36524;
  localparam int unsigned ERA_LAST_DAY = 146096;
  localparam int unsigned ERA_CMPS     = (1 << ERA_W) - 1;
  localparam int unsigned YEAR_MIN     = 1970;
  localparam int unsigned YEAR_MAX     = 2106;
  localparam int unsigned MILLIS_MAX   = 999;

  // 86400 = 2^7 * 675: shift first, then divide by 675
  localparam int unsigned SPD_SHIFT = 7;
  localparam int unsigned SPD_ODD   = 675;
  localparam int unsigned D675_SH   = 35;
  localparam longint unsigned D675_M = ((64'd1 << D675_SH) + SPD_ODD - 1) / SPD_ODD;
  localparam int unsigned D675_MW   = $clog2(D675_M + 1);
  localparam int unsigned D675_PW   = EPOCH_W - SPD_SHIFT + D675_MW;

  localparam int unsigned D1460_SH = 29;
  localparam longint unsigned D1460_M = ((64'd1 << D1460_SH) + 1459) / 1460;
  localparam int unsigned D1460_MW = $clog2(D1460_M + 1);
  localparam int unsigned D1460_PW = DOE_W + D1460_MW;
  localparam int unsigned Q1460_W  = 7;

  localparam int unsigned D365_SH = 27;
  localparam longint unsigned D365_M = ((64'd1 << D365_SH) + 364) / 365;
  localparam int unsigned D365_MW = $clog2(D365_M + 1);
  localparam int unsigned D365_PW = DOE_W + D365_MW;

  localparam int unsigned D3600_SH = 29;
  localparam longint unsigned D3600_M =
    ((64'd1 << D3600_SH) + SECS_PER_HR - 1) / SECS_PER_HR;
  localparam int unsigned D3600_MW = $clog2(D3600_M + 1);
  localparam int unsigned D3600_PW = SOD_W + D3600_MW;

  localparam int unsigned D60_SH = 18;
  localparam longint unsigned D60_M =
    ((64'd1 << D60_SH) + SECS_PER_MIN - 1) / SECS_PER_MIN;
  localparam int unsigned D60_MW = $clog2(D60_M + 1);
  localparam int unsigned D60_PW = REM_W + D60_MW;

  typedef struct packed {
    logic [STAGES-1:0] load;  // stage k takes new data at this edge
  } ecdt_ctl_t;

  // first day of March-based month mp within its year: (153*mp+2)/5
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] ofs;
    case (mp)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ===== sv/ecdt_if.sv =====
// Valid/ready channel interfaces for the epoch-to-civil-datetime unit.
// Depends on ecdt_pkg for field widths.
interface ecdt_in_if import ecdt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic [MS_W-1:0]    millis_in;

  modport source (output valid, output epoch_seconds, output millis_in, input ready);
  modport sink   (input valid, input epoch_seconds, input millis_in, output ready);
endinterface

interface ecdt_out_if import ecdt_pkg::*;;
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DOM_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic [MS_W-1:0]    millis_out;

  modport source (output valid, output valid_res, output year, output month,
                  output day_of_month, output hour, output minute, output second,
                  output millis_out, input ready);
  modport sink   (input valid, input valid_res, input year, input month,
                  input day_of_month, input hour, input minute, input second,
                  input millis_out, output ready);
endinterface

// ===== sv/epoch_seconds_to_civil_datetime_unit.sv =====
// Channel | dir | payload                                        | handshake
// in_chan | in  | epoch_seconds[31:0], millis_in[9:0]            | valid/ready
// out_chan| out | valid_res, year, month, day_of_month, hour,    | valid/ready
//         |     | minute, second, millis_out                     |
//
// Seven register stages.
// One beat per cycle unless the output stalls; depth is set by the reciprocal multipliers that
// replace the divisions by 86400, 1460, 365, 3600 and 60, at most one per stage in each path.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled output holds; upstream stages keep filling empty slots behind it.
module epoch_seconds_to_civil_datetime_unit import ecdt_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  ecdt_in_if.sink      in_chan,
  ecdt_out_if.source   out_chan
);

  ecdt_ctl_t          ctl;
  logic [DAYS_W-1:0]  days;
  logic [YEAR_W-1:0]  year6;
  logic [MONTH_W-1:0] month6;
  logic [DOM_W-1:0]   dom6;
  logic [HOUR_W-1:0]  hour6;
  logic [MIN_W-1:0]   min6;
  logic [SEC_W-1:0]   sec6;
  logic [MS_W-1:0]    ms6;

  ecdt_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ctl       (ctl)
  );

  ecdt_date u_date (
    .clk           (clk),
    .ctl           (ctl),
    .epoch_seconds (in_chan.epoch_seconds),
    .days          (days),
    .year          (year6),
    .month         (month6),
    .day_of_month  (dom6)
  );

  ecdt_tod u_tod (
    .clk           (clk),
    .ctl           (ctl),
    .epoch_seconds (in_chan.epoch_seconds),
    .millis_in     (in_chan.millis_in),
    .days          (days),
    .hour          (hour6),
    .minute        (min6),
    .second        (sec6),
    .millis        (ms6)
  );

  // stage 7: range check, zero every field of a rejected beat
  logic               ok_c;
  logic               valid_res_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DOM_W-1:0]   dom_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   min_r;
  logic [SEC_W-1:0]   sec_r;
  logic [MS_W-1:0]    ms_r;

  assign ok_c = (ms6 <= MS_W'(MILLIS_MAX)) && (year6 >= YEAR_W'(YEAR_MIN))
             && (year6 <= YEAR_W'(YEAR_MAX));

  always_ff @(posedge clk) begin
    if (ctl.load[STAGES-1]) begin
      valid_res_r <= ok_c;
      year_r      <= ok_c ? year6  : '0;
      month_r     <= ok_c ? month6 : '0;
      dom_r       <= ok_c ? dom6   : '0;
      hour_r      <= ok_c ? hour6  : '0;
      min_r       <= ok_c ? min6   : '0;
      sec_r       <= ok_c ? sec6   : '0;
      ms_r        <= ok_c ? ms6    : '0;
    end
  end

  assign out_chan.valid_res    = valid_res_r;
  assign out_chan.year         = year_r;
  assign out_chan.month        = month_r;
  assign out_chan.day_of_month = dom_r;
  assign out_chan.hour         = hour_r;
  assign out_chan.minute       = min_r;
  assign out_chan.second       = sec_r;
  assign out_chan.millis_out   = ms_r;

endmodule

// ===== sv/ecdt_ctl.sv =====
// Stage valid bits and per-stage load enables for the datetime pipeline.
// A stage loads when it is empty or the stage after it moves. Uses ecdt_pkg.
module ecdt_ctl import ecdt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ecdt_ctl_t ctl
);

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES-1:0] v_prev;
  logic [STAGES:0]   rdy;

  assign v_prev = {v_r[STAGES-2:0], in_valid};

  always_comb begin
    rdy[STAGES] = out_ready;
    for (int i = STAGES - 1; i >= 0; i--) begin
      rdy[i] = ~v_r[i] | rdy[i+1];
    end
  end

  // hold a full stage whose successor is stalled, else take the upstream beat
  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      v_nxt[i] = rdy[i] ? v_prev[i] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.load  = rdy[STAGES-1:0];
  assign in_ready  = rdy[0];
  assign out_valid = v_r[STAGES-1];

endmodule

// ===== sv/ecdt_date.sv =====
// Day-count to Gregorian date datapath: stages one to six of the pipeline.
// Era / day-of-era method, divisions by reciprocal multiply. Uses ecdt_pkg.
module ecdt_date import ecdt_pkg::*; (
  input  logic               clk,
  input  ecdt_ctl_t          ctl,
  input  logic [EPOCH_W-1:0] epoch_seconds,
  output logic [DAYS_W-1:0]  days,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DOM_W-1:0]   day_of_month
);

  // stage 1: days = secs / 86400
  logic [D675_PW-1:0] d675_prod;
  logic [DAYS_W-1:0]  days_r;

  assign d675_prod = D675_PW'(epoch_seconds[EPOCH_W-1:SPD_SHIFT]) * D675_PW'(D675_M);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) days_r <= d675_prod[D675_SH +: DAYS_W];
  end
  assign days = days_r;

  // stage 2: shift origin to 0000-03-01, split into era and day of era
  logic [Z_W-1:0]   z_c;
  logic [ERA_W-1:0] era_c;
  logic [Z_W-1:0]   doe_c;
  logic [ERA_W-1:0] era2_r;
  logic [DOE_W-1:0] doe2_r;

  assign z_c = Z_W'(days_r) + Z_W'(DAY_SHIFT);

  always_comb begin
    era_c = '0;
    for (int k = 1; k <= ERA_CMPS; k++) begin
      if (z_c >= Z_W'(k * DAYS_PER_ERA)) era_c = era_c + 1'b1;
    end
  end

  assign doe_c = z_c - Z_W'(era_c) * Z_W'(DAYS_PER_ERA);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      era2_r <= era_c;
      doe2_r <= doe_c[DOE_W-1:0];
    end
  end

  // stage 3: doe - doe/1460 + doe/36524 - doe/146096
  logic [D1460_PW-1:0] d1460_prod;
  logic [Q1460_W-1:0]  q1460_c;
  logic [Q36_W-1:0]    q36524_c;
  logic                last_day_c;
  logic [DOE_W-1:0]    adj_c;
  logic [ERA_W-1:0]    era3_r;
  logic [DOE_W-1:0]    doe3_r;
  logic [DOE_W-1:0]    adj3_r;

  assign d1460_prod = D1460_PW'(doe2_r) * D1460_PW'(D1460_M);
  assign q1460_c    = d1460_prod[D1460_SH +: Q1460_W];
  assign last_day_c = (doe2_r == DOE_W'(ERA_LAST_DAY));

  always_comb begin
    q36524_c = '0;
    for (int k = 1; k <= 4; k++) begin
      if (doe2_r >= DOE_W'(k * DAYS_PER_CEN)) q36524_c = q36524_c + 1'b1;
    end
  end

  assign adj_c = doe2_r - DOE_W'(q1460_c) + DOE_W'(q36524_c) - DOE_W'(last_day_c);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      era3_r <= era2_r;
      doe3_r <= doe2_r;
      adj3_r <= adj_c;
    end
  end

  // stage 4: year of era = adj / 365
  logic [D365_PW-1:0] d365_prod;
  logic [ERA_W-1:0]   era4_r;
  logic [DOE_W-1:0]   doe4_r;
  logic [YOE_W-1:0]   yoe4_r;

  assign d365_prod = D365_PW'(adj3_r) * D365_PW'(D365_M);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      era4_r <= era3_r;
      doe4_r <= doe3_r;
      yoe4_r <= d365_prod[D365_SH +: YOE_W];
    end
  end

  // stage 5: day of March-based year
  logic [Q100_W-1:0] q100_c;
  logic [DOE_W-1:0]  ybase_c;
  logic [DOE_W-1:0]  doy_c;
  logic [ERA_W-1:0]  era5_r;
  logic [YOE_W-1:0]  yoe5_r;
  logic [DOY_W-1:0]  doy5_r;

  always_comb begin
    q100_c = '0;
    for (int k = 1; k <= 3; k++) begin
      if (yoe4_r >= YOE_W'(k * 100)) q100_c = q100_c + 1'b1;
    end
  end

  assign ybase_c = DOE_W'(yoe4_r) * DOE_W'(365) + DOE_W'(yoe4_r >> 2) - DOE_W'(q100_c);
  assign doy_c   = doe4_r - ybase_c;

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      era5_r <= era4_r;
      yoe5_r <= yoe4_r;
      doy5_r <= doy_c[DOY_W-1:0];
    end
  end

  // stage 6: month, day and January-based year
  logic [REM_W-1:0]   doy5x_c;
  logic [MP_W-1:0]    mp_c;
  logic [MONTH_W-1:0] mm_c;
  logic [DOY_W-1:0]   dd_c;
  logic [YEAR_W-1:0]  yy_c;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DOM_W-1:0]   dom_r;

  assign doy5x_c = REM_W'(doy5_r) * REM_W'(5) + REM_W'(2);

  always_comb begin
    mp_c = '0;
    for (int k = 1; k <= 11; k++) begin
      if (doy5x_c >= REM_W'(k * 153)) mp_c = mp_c + 1'b1;
    end
  end

  assign mm_c = (mp_c < MP_W'(10)) ? MONTH_W'(mp_c + MP_W'(3)) : MONTH_W'(mp_c - MP_W'(9));
  assign dd_c = doy5_r - month_start(mp_c) + DOY_W'(1);
  assign yy_c = YEAR_W'(yoe5_r) + YEAR_W'(era5_r) * YEAR_W'(400)
              + YEAR_W'(mm_c <= MONTH_W'(2));

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      year_r  <= yy_c;
      month_r <= mm_c;
      dom_r   <= dd_c[DOM_W-1:0];
    end
  end

  assign year         = year_r;
  assign month        = month_r;
  assign day_of_month = dom_r;

endmodule

// ===== sv/ecdt_tod.sv =====
// Time-of-day datapath: stages one to six, aligned with the date stages.
// Splits the second of day into hour, minute, second; carries milliseconds. Uses ecdt_pkg.
module ecdt_tod import ecdt_pkg::*; (
  input  logic               clk,
  input  ecdt_ctl_t          ctl,
  input  logic [EPOCH_W-1:0] epoch_seconds,
  input  logic [MS_W-1:0]    millis_in,
  input  logic [DAYS_W-1:0]  days,
  output logic [HOUR_W-1:0]  hour,
  output logic [MIN_W-1:0]   minute,
  output logic [SEC_W-1:0]   second,
  output logic [MS_W-1:0]    millis
);

  logic [MS_W-1:0] ms_r [STAGES-1];

  // carry the millisecond field alongside the date stages
  always_ff @(posedge clk) begin
    if (ctl.load[0]) ms_r[0] <= millis_in;
    for (int i = 1; i < STAGES - 1; i++) begin
      if (ctl.load[i]) ms_r[i] <= ms_r[i-1];
    end
  end
  assign millis = ms_r[STAGES-2];

  // stage 1: keep the low bits; second of day fits them
  logic [SOD_W-1:0] seclo1_r;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) seclo1_r <= epoch_seconds[SOD_W-1:0];
  end

  // stage 2: sod = secs - days*86400, modulo 2^17
  logic [SOD_W-1:0] sod_c;
  logic [SOD_W-1:0] sod2_r;

  assign sod_c = seclo1_r - SOD_W'(days) * SOD_W'(SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) sod2_r <= sod_c;
  end

  // stage 3: hour = sod / 3600
  logic [D3600_PW-1:0] d3600_prod;
  logic [SOD_W-1:0]    sod3_r;
  logic [HOUR_W-1:0]   hour3_r;

  assign d3600_prod = D3600_PW'(sod2_r) * D3600_PW'(D3600_M);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      sod3_r  <= sod2_r;
      hour3_r <= d3600_prod[D3600_SH +: HOUR_W];
    end
  end

  // stage 4: second of hour
  logic [SOD_W-1:0]  rem_c;
  logic [HOUR_W-1:0] hour4_r;
  logic [REM_W-1:0]  rem4_r;

  assign rem_c = sod3_r - SOD_W'(hour3_r) * SOD_W'(SECS_PER_HR);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      hour4_r <= hour3_r;
      rem4_r  <= rem_c[REM_W-1:0];
    end
  end

  // stage 5: minute = rem / 60
  logic [D60_PW-1:0] d60_prod;
  logic [HOUR_W-1:0] hour5_r;
  logic [REM_W-1:0]  rem5_r;
  logic [MIN_W-1:0]  min5_r;

  assign d60_prod = D60_PW'(rem4_r) * D60_PW'(D60_M);

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      hour5_r <= hour4_r;
      rem5_r  <= rem4_r;
      min5_r  <= d60_prod[D60_SH +: MIN_W];
    end
  end

  // stage 6: second of minute
  logic [REM_W-1:0]  sec_c;
  logic [HOUR_W-1:0] hour6_r;
  logic [MIN_W-1:0]  min6_r;
  logic [SEC_W-1:0]  sec6_r;

  assign sec_c = rem5_r - REM_W'(min5_r) * REM_W'(SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec_c[SEC_W-1:0];
    end
  end

  assign hour   = hour6_r;
  assign minute = min6_r;
  assign second = sec6_r;

endmodule

// ===== sv/ecdt_checker.sv =====
// Port-level checks for the epoch-to-civil-datetime unit, bound to the top level.
// Depends on ecdt_pkg and the top-level channel interfaces.
module ecdt_checker import ecdt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               valid_res,
  input logic [YEAR_W-1:0]  year,
  input logic [MONTH_W-1:0] month,
  input logic [DOM_W-1:0]   day_of_month,
  input logic [HOUR_W-1:0]  hour,
  input logic [MIN_W-1:0]   minute,
  input logic [SEC_W-1:0]   second,
  input logic [MS_W-1:0]    millis_out
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused while pipeline can move");

  a_reject_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> year == '0 && month == '0 && day_of_month == '0
      && hour == '0 && minute == '0 && second == '0 && millis_out == '0)
    else $error("rejected beat carries nonzero fields");

  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && valid_res |-> year >= YEAR_W'(YEAR_MIN) && year <= YEAR_W'(YEAR_MAX)
      && month >= MONTH_W'(1) && month <= MONTH_W'(12) && day_of_month != '0
      && hour <= HOUR_W'(23) && minute <= MIN_W'(59) && second <= SEC_W'(59)
      && millis_out <= MS_W'(MILLIS_MAX))
    else $error("accepted beat has a field out of range");

endmodule

bind epoch_seconds_to_civil_datetime_unit ecdt_checker u_ecdt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .valid_res    (out_chan.valid_res),
  .year         (out_chan.year),
  .month        (out_chan.month),
  .day_of_month (out_chan.day_of_month),
  .hour         (out_chan.hour),
  .minute       (out_chan.minute),
  .second       (out_chan.second),
  .millis_out   (out_chan.millis_out)
);

// ===== verif/civil_datetime_checker.sv =====
// Checker for the epoch-to-civil-datetime unit: watches the input and result channels.
// Converts each input beat to its calendar date and time and compares it with the result beats.
// Depends on ecdt_pkg and the channel interfaces in ecdt_if.sv.
module civil_datetime_checker import ecdt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ecdt_in_if   in_mon,
  ecdt_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   invalid_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DAY_SECS      = 86400;
  localparam int unsigned MARCH_ORIGIN  = 719468;
  localparam int unsigned ERA_DAYS      = 146097;
  localparam int unsigned MS_LIMIT      = 999;
  localparam int unsigned FIRST_YEAR    = 1970;
  localparam int unsigned LAST_YEAR     = 2106;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [MS_W-1:0]    millis;
  } civil_t;

  civil_t expected_dates[$];
  int     errs;
  int     n_checked;
  int     n_invalid;

  function automatic civil_t civil_from_epoch(input logic [EPOCH_W-1:0] secs,
                                              input logic [MS_W-1:0] ms);
    civil_t      r;
    logic [31:0] days, sod, z, era, doe, yoe, doy, mp, dd, mm, yy;
    r = '0;
    days = secs / DAY_SECS;
    sod  = secs % DAY_SECS;
    // shift the origin to 0000-03-01 so the leap day ends the year
    z    = days + MARCH_ORIGIN;
    era  = z / ERA_DAYS;
    doe  = z - era * ERA_DAYS;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mm   = (mp < 10) ? mp + 3 : mp - 9;
    yy   = yoe + era * 400 + ((mm <= 2) ? 1 : 0);
    if (ms > MS_LIMIT || yy < FIRST_YEAR || yy > LAST_YEAR) begin
      return r;
    end
    r.ok     = 1'b1;
    r.year   = yy[YEAR_W-1:0];
    r.month  = mm[MONTH_W-1:0];
    r.dom    = dd[DOM_W-1:0];
    r.hour   = 5'(sod / 3600);
    r.minute = 6'((sod % 3600) / 60);
    r.second = 6'(sod % 60);
    r.millis = ms;
    return r;
  endfunction

  initial begin
    errs = 0;
    n_checked = 0;
    n_invalid = 0;
    fail_count = 0;
    pending = 0;
    checked = 0;
    invalid_seen = 0;
  end

  always @(posedge clk) begin
    civil_t got, want;
    if (rst_n) begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got = '{out_mon.valid_res, out_mon.year, out_mon.month, out_mon.day_of_month,
                out_mon.hour, out_mon.minute, out_mon.second, out_mon.millis_out};
        if (expected_dates.size() == 0) begin
          errs++;
          if (errs <= REPORT_LIMIT)
            $display("[%0t] result beat with nothing expected: ok=%0b %0d-%0d-%0d",
                     $realtime, got.ok, got.year, got.month, got.dom);
        end else begin
          want = expected_dates.pop_front();
          n_checked++;
          if (!got.ok) n_invalid++;
          if (got.ok !== want.ok || got.year !== want.year || got.month !== want.month ||
              got.dom !== want.dom || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second ||
              got.millis !== want.millis) begin
            errs++;
            if (errs <= REPORT_LIMIT)
              $display({"[%0t] mismatch: expected ok=%0b %0d-%0d-%0d %0d:%0d:%0d.%0d",
                        " got ok=%0b %0d-%0d-%0d %0d:%0d:%0d.%0d"}, $realtime,
                       want.ok, want.year, want.month, want.dom,
                       want.hour, want.minute, want.second, want.millis,
                       got.ok, got.year, got.month, got.dom,
                       got.hour, got.minute, got.second, got.millis);
          end
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        expected_dates.push_back(civil_from_epoch(in_mon.epoch_seconds, in_mon.millis_in));
    end
    // publish after this edge's updates so readers see a settled value
    fail_count   <= errs;
    pending      <= expected_dates.size();
    checked      <= n_checked;
    invalid_seen <= n_invalid;
  end

endmodule

// ===== verif/epoch_seconds_to_civil_datetime_unit_tb.sv =====
// Top of the testbench for epoch_seconds_to_civil_datetime_unit: clock, reset, stimulus.
// Sends directed and random timestamps with random gaps and stalls; checking is in
// civil_datetime_checker. Depends on ecdt_pkg, ecdt_if.sv and the checker module.
module epoch_seconds_to_civil_datetime_unit_tb;
  import ecdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_STAMPS = 850;
  localparam int STEADY_FIRST = 400;
  localparam int STEADY_LAST  = 550;
  localparam int HOLD_AT      = 600;
  localparam int DRAIN_CYCLES = 3 * STAGES;
  localparam int QUIET_LIMIT  = 4000;
  localparam int IDLE_PCT     = 38;

  logic clk;
  logic rst_n;
  logic steady;
  int   fail_count, pending, checked, invalid_seen;
  int   sent;

  ecdt_in_if  in_if();
  ecdt_out_if out_if();

  epoch_seconds_to_civil_datetime_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  civil_datetime_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .invalid_seen (invalid_seen)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic send_stamp(input logic [EPOCH_W-1:0] secs, input logic [MS_W-1:0] ms);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.epoch_seconds <= secs;
    in_if.millis_in     <= ms;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sent++;
  endtask

  // hold off the sender until every result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [EPOCH_W-1:0] random_epoch();
    logic [EPOCH_W-1:0] days, sod;
    int unsigned        mode;
    mode = $urandom_range(0, 9);
    if (mode <= 4) return $urandom();
    if (mode <= 7) begin
      // land on or next to a midnight, or on a random second of the day
      days = $urandom_range(0, 49709);
      case ($urandom_range(0, 4))
        0:       sod = 0;
        1:       sod = 1;
        2:       sod = 86398;
        3:       sod = 86399;
        default: sod = $urandom_range(0, 86399);
      endcase
      return days * 86400 + sod;
    end
    if (mode == 8) return $urandom_range(0, 200000);
    return 32'hFFFF_FFFF - $urandom_range(0, 200000);
  endfunction

  function automatic logic [MS_W-1:0] random_millis();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return MS_W'($urandom_range(1000, 1023));
    if (pick < 20) return (pick < 18) ? 10'd999 : 10'd0;
    return MS_W'($urandom_range(0, 999));
  endfunction

  initial begin
    logic [EPOCH_W-1:0] epochs[$];
    logic [MS_W-1:0]    millis[$];
    rst_n               = 1'b0;
    steady              = 1'b0;
    sent                = 0;
    in_if.valid         = 1'b0;
    in_if.epoch_seconds = '0;
    in_if.millis_in     = '0;
    out_if.ready        = 1'b0;

    // epoch start, last second, millisecond limits, midnights, leap days,
    // the skipped 2100 leap day, the 2^31 rollover and the final day
    epochs = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd12345, 32'd86399, 32'd86400,
               32'd68169600, 32'd68255999, 32'd951782400, 32'd951868800,
               32'd946684799, 32'd946684800, 32'd4107542399, 32'd4107542400,
               32'd2147483647, 32'd2147483648, 32'd4294944000, 32'd1023,
               32'hFFFF_FFFF, 32'd31535999, 32'd31536000, 32'hAAAA_AAAA,
               32'h5555_5555};
    millis = '{10'd0, 10'd999, 10'd999, 10'd1000, 10'd1023, 10'd500, 10'd1,
               10'd0, 10'd7, 10'd123, 10'd456, 10'd999, 10'd0, 10'd1, 10'd2,
               10'd3, 10'd4, 10'd5, 10'd1023, 10'd1000, 10'd998, 10'd0,
               10'h2AA, 10'h155};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (epochs[i]) send_stamp(epochs[i], millis[i]);
    drain_results();

    for (int n = 0; n < RANDOM_STAMPS; n++) begin
      steady = (n >= STEADY_FIRST && n < STEADY_LAST);
      if (n == HOLD_AT) drain_results();
      send_stamp(random_epoch(), random_millis());
    end
    steady = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d timestamps, checked %0d results, %0d of them flagged invalid",
             sent, checked, invalid_seen);
    $display("covered leap days, century rules, midnights and the 2106 upper end");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // end the run if no beat moves on either channel for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d results outstanding", quiet, pending);
    $display("status: fail");
    $finish;
  end

endmodule
